// File: design/sqb_pkg.sv
// sqb_pkg: shared types and constants for the sprite quad batcher.
// Request and result structs, controller command and status structs, sine coefficients.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sqb_pkg;

    localparam int BATCH_SPRITES_DEF = 1024;

    // Q30 coefficients of the quarter-wave sine polynomial
    localparam logic signed [33:0] C1 = 34'sd1686629713;
    localparam logic signed [33:0] C3 = 34'sd693598668;
    localparam logic signed [33:0] C5 = 34'sd85569306;
    localparam logic signed [33:0] C7 = 34'sd5026995;
    localparam logic signed [33:0] C9 = 34'sd172273;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_SPRITE = 2'd1,
        OP_BLEND  = 2'd2,
        OP_END    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_DRAW   = 2'd1,
        KIND_BLEND  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        MS_OX,
        MS_OY,
        MS_X2,
        MS_POLY,
        MS_FIN,
        MS_ROT_A,
        MS_ROT_B,
        MS_ROT_C,
        MS_ROT_D
    } mstep_t;

    typedef struct packed {
        op_t          op;
        logic [15:0]  texture_id;
        logic [63:0]  position;
        logic [63:0]  extent;
        logic [31:0]  pivot;
        logic [15:0]  angle;
        logic [63:0]  source_rect;
        logic [31:0]  rgba;
        logic         blend_select;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        vertex_rgba;
        logic [15:0]        batch_texture;
        logic [10:0]        batch_sprites;
        logic [15:0]        draw_number;
        logic               blend_mode;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic   capture;
        logic   mul_en;
        logic   wb_en;
        mstep_t mstep;
        logic [1:0] coef;
        logic   trig_cos;
        logic [1:0] corner;
        logic   out_load;
        kind_t  out_kind;
        logic   out_last;
        logic   frame_begin;
        logic   frame_end;
        logic   draw_close;
        logic   sprite_done;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic frame_active;
        logic tex_change;
        logic batch_nonempty;
        logic batch_full;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// File: design/sqb_datapath.sv
// sqb_datapath: request register, batch state, shared multiplier, sine and corner math,
// output register. Driven by sqb_ctrl commands; depends on sqb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sqb_datapath #(
    parameter int BatchSprites = sqb_pkg::BATCH_SPRITES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sqb_pkg::in_item_t s_data,
    input  wire sqb_pkg::cmd_t     cmd,
    output sqb_pkg::status_t       status,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output sqb_pkg::out_item_t     m_data
);
    localparam int SprW = $clog2(BatchSprites + 1);

    sqb_pkg::in_item_t  item_reg;
    sqb_pkg::out_item_t m_data_reg, m_data_next;
    logic               m_valid_reg;

    logic            frame_active_reg;
    logic [SprW-1:0] sprites_reg;
    logic [15:0]     bound_reg;
    logic [15:0]     draws_reg;

    logic signed [35:0] ox_reg, oy_reg, ex_reg, ey_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic [30:0]        x2_reg;
    logic signed [33:0] p_reg;
    logic signed [69:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic signed [37:0] rx_reg, ry_reg;

    logic signed [31:0] pos_x, pos_y, w, h;
    logic signed [15:0] gx, gy;
    logic [15:0]        u0, v0, u1, v1;
    logic [16:0]        u_sum, v_sum;

    logic [15:0]        ang_t;
    logic [14:0]        r, rr;
    logic               neg;
    logic signed [35:0] cx, cy;
    logic signed [35:0] mul_a;
    logic signed [33:0] mul_b;

    logic signed [69:0] ofs_full;
    logic signed [35:0] ofs_new;
    logic signed [33:0] coef_v;
    logic signed [69:0] fin_full;
    logic signed [15:0] fin_mag, fin_val;
    logic signed [51:0] acc_sum, rot_full;
    logic signed [37:0] rx_use, ry_use;
    logic               ang_zero, hi_corner_x;

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        logic signed [31:0] res;
        if (v > 39'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -39'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign pos_x = item_reg.position[63:32];
    assign pos_y = item_reg.position[31:0];
    assign w     = item_reg.extent[63:32];
    assign h     = item_reg.extent[31:0];
    assign gx    = item_reg.pivot[31:16];
    assign gy    = item_reg.pivot[15:0];
    assign u0    = item_reg.source_rect[63:48];
    assign v0    = item_reg.source_rect[47:32];
    assign u_sum = {1'b0, u0} + {1'b0, item_reg.source_rect[31:16]};
    assign v_sum = {1'b0, v0} + {1'b0, item_reg.source_rect[15:0]};
    assign u1    = u_sum[16] ? 16'hFFFF : u_sum[15:0];
    assign v1    = v_sum[16] ? 16'hFFFF : v_sum[15:0];

    assign ang_zero = (item_reg.angle == 16'd0);
    assign ang_t    = cmd.trig_cos ? item_reg.angle + 16'd16384 : item_reg.angle;
    assign rr       = {1'b0, ang_t[13:0]};
    assign r        = ang_t[14] ? 15'd16384 - rr : rr;
    assign neg      = ang_t[15];

    assign hi_corner_x = cmd.corner[0] ^ cmd.corner[1];
    assign cx = hi_corner_x ? ex_reg : ox_reg;
    assign cy = cmd.corner[1] ? ey_reg : oy_reg;

    always_comb begin
        unique case (cmd.mstep)
            sqb_pkg::MS_OX: begin
                mul_a = 36'(w);
                mul_b = 34'(gx);
            end
            sqb_pkg::MS_OY: begin
                mul_a = 36'(h);
                mul_b = 34'(gy);
            end
            sqb_pkg::MS_X2: begin
                mul_a = {21'd0, r};
                mul_b = {19'd0, r};
            end
            sqb_pkg::MS_POLY: begin
                mul_a = {5'd0, x2_reg};
                mul_b = p_reg;
            end
            sqb_pkg::MS_FIN: begin
                mul_a = {21'd0, r};
                mul_b = p_reg;
            end
            sqb_pkg::MS_ROT_A: begin
                mul_a = cx;
                mul_b = 34'(cos_reg);
            end
            sqb_pkg::MS_ROT_B: begin
                mul_a = cy;
                mul_b = 34'(sin_reg);
            end
            sqb_pkg::MS_ROT_C: begin
                mul_a = cx;
                mul_b = 34'(sin_reg);
            end
            sqb_pkg::MS_ROT_D: begin
                mul_a = cy;
                mul_b = 34'(cos_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        unique case (cmd.coef)
            2'd0:    coef_v = sqb_pkg::C7;
            2'd1:    coef_v = sqb_pkg::C5;
            2'd2:    coef_v = sqb_pkg::C3;
            default: coef_v = sqb_pkg::C1;
        endcase
    end

    // offset = round(-pivot * size / 4096)
    assign ofs_full = (70'sd2048 - prod_reg) >>> 12;
    assign ofs_new  = ofs_full[35:0];

    always_comb begin
        fin_full = ((prod_reg >>> 14) + 70'sd32768) >>> 16;
        if (fin_full > 70'sd16384) begin
            fin_mag = 16'sd16384;
        end else if (fin_full < 70'sd0) begin
            fin_mag = 16'sd0;
        end else begin
            fin_mag = fin_full[15:0];
        end
        fin_val = neg ? -fin_mag : fin_mag;
    end

    assign acc_sum  = (cmd.mstep == sqb_pkg::MS_ROT_B) ? acc_reg - prod_reg[51:0]
                                                       : acc_reg + prod_reg[51:0];
    assign rot_full = (acc_sum + 52'sd8192) >>> 14;

    assign rx_use = ang_zero ? 38'(cx) : rx_reg;
    assign ry_use = ang_zero ? 38'(cy) : ry_reg;

    always_comb begin
        m_data_next = '0;
        m_data_next.kind = cmd.out_kind;
        m_data_next.last = cmd.out_last;
        unique case (cmd.out_kind)
            sqb_pkg::KIND_VERTEX: begin
                m_data_next.vertex_x      = sat32(39'(pos_x) + 39'(rx_use));
                m_data_next.vertex_y      = sat32(39'(pos_y) + 39'(ry_use));
                m_data_next.tex_u         = hi_corner_x ? u1 : u0;
                m_data_next.tex_v         = cmd.corner[1] ? v1 : v0;
                m_data_next.vertex_rgba   = item_reg.rgba;
                m_data_next.batch_texture = item_reg.texture_id;
            end
            sqb_pkg::KIND_DRAW: begin
                m_data_next.batch_texture = bound_reg;
                m_data_next.batch_sprites = 11'(sprites_reg);
                m_data_next.draw_number   = draws_reg;
            end
            sqb_pkg::KIND_BLEND: begin
                m_data_next.blend_mode = (item_reg.op == sqb_pkg::OP_BLEND) &&
                                         item_reg.blend_select;
            end
            default: begin
                m_data_next.kind = sqb_pkg::KIND_BLEND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.mul_en) begin
            prod_reg <= 70'(mul_a) * 70'(mul_b);
        end
        if (cmd.wb_en) begin
            unique case (cmd.mstep)
                sqb_pkg::MS_OX: begin
                    ox_reg <= ofs_new;
                    ex_reg <= ofs_new + 36'(w);
                end
                sqb_pkg::MS_OY: begin
                    oy_reg <= ofs_new;
                    ey_reg <= ofs_new + 36'(h);
                end
                sqb_pkg::MS_X2: begin
                    x2_reg <= {prod_reg[28:0], 2'b00};
                    p_reg  <= sqb_pkg::C9;
                end
                sqb_pkg::MS_POLY: begin
                    p_reg <= coef_v - 34'(prod_reg >>> 30);
                end
                sqb_pkg::MS_FIN: begin
                    if (cmd.trig_cos) begin
                        cos_reg <= fin_val;
                    end else begin
                        sin_reg <= fin_val;
                    end
                end
                sqb_pkg::MS_ROT_A, sqb_pkg::MS_ROT_C: begin
                    acc_reg <= prod_reg[51:0];
                end
                sqb_pkg::MS_ROT_B: begin
                    rx_reg <= rot_full[37:0];
                end
                sqb_pkg::MS_ROT_D: begin
                    ry_reg <= rot_full[37:0];
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_active_reg <= 1'b0;
            sprites_reg      <= '0;
            bound_reg        <= '0;
            draws_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            priority if (cmd.frame_begin) begin
                frame_active_reg <= 1'b1;
                sprites_reg      <= '0;
                bound_reg        <= '0;
                draws_reg        <= '0;
            end else if (cmd.draw_close) begin
                sprites_reg <= '0;
                if (draws_reg != 16'hFFFF) begin
                    draws_reg <= draws_reg + 16'd1;
                end
            end else if (cmd.sprite_done) begin
                sprites_reg <= sprites_reg + SprW'(1);
                bound_reg   <= item_reg.texture_id;
            end else if (cmd.frame_end) begin
                frame_active_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.op             = item_reg.op;
    assign status.frame_active   = frame_active_reg;
    assign status.tex_change     = (bound_reg != 16'd0) && (bound_reg != item_reg.texture_id);
    assign status.batch_nonempty = (sprites_reg != '0);
    assign status.batch_full     = (sprites_reg >= SprW'(BatchSprites));
    assign status.out_free       = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire

// File: design/sqb_ctrl.sv
// sqb_ctrl: request sequencer for the sprite quad batcher.
// Walks decode, batch close, multiply steps and result emission; depends on sqb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sqb_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire sqb_pkg::status_t status,
    output sqb_pkg::cmd_t         cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DRAW,
        ST_BLEND,
        ST_MUL,
        ST_WB,
        ST_EMIT
    } state_t;

    localparam logic [4:0] STEP_OY      = 5'd1;
    localparam logic [4:0] STEP_SIN_X2  = 5'd2;
    localparam logic [4:0] STEP_SIN_FIN = 5'd7;
    localparam logic [4:0] STEP_COS_X2  = 5'd8;
    localparam logic [4:0] STEP_COS_FIN = 5'd13;
    localparam logic [4:0] STEP_ROT     = 5'd14;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [4:0] rot_k, coef_k;
    logic       close_sprite;

    assign rot_k  = step_reg - STEP_ROT;
    assign coef_k = (step_reg < STEP_COS_X2) ? step_reg - 5'd3 : step_reg - 5'd9;
    assign close_sprite = (status.tex_change || status.batch_full) && status.batch_nonempty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.coef       = coef_k[1:0];
        cmd.corner     = rot_k[3:2];
        cmd.trig_cos   = (step_reg >= STEP_COS_X2) && (step_reg < STEP_ROT);
        cmd.out_kind   = sqb_pkg::KIND_VERTEX;
        priority if (step_reg == 5'd0) begin
            cmd.mstep = sqb_pkg::MS_OX;
        end else if (step_reg == STEP_OY) begin
            cmd.mstep = sqb_pkg::MS_OY;
        end else if (step_reg == STEP_SIN_X2 || step_reg == STEP_COS_X2) begin
            cmd.mstep = sqb_pkg::MS_X2;
        end else if (step_reg == STEP_SIN_FIN || step_reg == STEP_COS_FIN) begin
            cmd.mstep = sqb_pkg::MS_FIN;
        end else if (step_reg < STEP_ROT) begin
            cmd.mstep = sqb_pkg::MS_POLY;
        end else if (rot_k[1:0] == 2'd0) begin
            cmd.mstep = sqb_pkg::MS_ROT_A;
        end else if (rot_k[1:0] == 2'd1) begin
            cmd.mstep = sqb_pkg::MS_ROT_B;
        end else if (rot_k[1:0] == 2'd2) begin
            cmd.mstep = sqb_pkg::MS_ROT_C;
        end else begin
            cmd.mstep = sqb_pkg::MS_ROT_D;
        end

        s_ready    = 1'b0;
        state_next = state_reg;
        step_next  = step_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                step_next = '0;
                priority if (status.op == sqb_pkg::OP_BEGIN) begin
                    cmd.frame_begin = 1'b1;
                    state_next      = ST_IDLE;
                end else if (!status.frame_active) begin
                    state_next = ST_IDLE;
                end else if (status.op == sqb_pkg::OP_SPRITE) begin
                    state_next = close_sprite ? ST_DRAW : ST_MUL;
                end else begin
                    state_next = status.batch_nonempty ? ST_DRAW : ST_BLEND;
                end
            end
            ST_DRAW: begin
                if (status.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_kind   = sqb_pkg::KIND_DRAW;
                    cmd.draw_close = 1'b1;
                    state_next = (status.op == sqb_pkg::OP_SPRITE) ? ST_MUL : ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = sqb_pkg::KIND_BLEND;
                    cmd.out_last  = 1'b1;
                    cmd.frame_end = (status.op == sqb_pkg::OP_END);
                    state_next    = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.wb_en = 1'b1;
                if (cmd.mstep == sqb_pkg::MS_ROT_D) begin
                    state_next = ST_EMIT;
                end else begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_MUL;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (rot_k[3:2] == 2'd3);
                    if (rot_k[3:2] == 2'd3) begin
                        cmd.sprite_done = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        step_next  = step_reg + 5'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: design/sprite_quad_batcher.sv
// sprite_quad_batcher: top level, joins the sequencer sqb_ctrl and the datapath sqb_datapath.
// Depends on sqb_pkg.
//
// channel | dir | handshake          | payload
// s_      | in  | s_valid / s_ready  | s_data (sqb_pkg::in_item_t)
// m_      | out | m_valid / m_ready  | m_data (sqb_pkg::out_item_t)
//
// One request at a time. A sprite passes accept and decode, any due batch close, then 30
// steps of the single shared multiplier, each a multiply and a write-back, with a vertex
// emit after each corner's rotation steps. Blend and frame-end requests pass accept, decode,
// any due batch close and the blend emit; begin and idle-frame requests end after decode.
// Reset (aresetn low, synchronous) clears the frame, batch and sequencer state.
// A stalled m_ready holds the sequencer at its next emit; the last result of a request
// may wait in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module sprite_quad_batcher #(
    parameter int BATCH_SPRITES = sqb_pkg::BATCH_SPRITES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sqb_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sqb_pkg::out_item_t      m_data
);
    sqb_pkg::cmd_t    cmd;
    sqb_pkg::status_t status;

    sqb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sqb_datapath #(
        .BatchSprites (BATCH_SPRITES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );
endmodule
`default_nettype wire

// File: design/sqb_checker.sv
// sqb_checker: port-level assertions for sprite_quad_batcher, bound to the top level.
// Depends on sqb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sqb_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire sqb_pkg::out_item_t m_data
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in work");

    a_blend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == sqb_pkg::KIND_BLEND |-> m_data.last)
        else $error("blend result not final");

    a_draw_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == sqb_pkg::KIND_DRAW |-> !m_data.last)
        else $error("draw command marked final");
endmodule

bind sprite_quad_batcher sqb_checker u_sqb_checker (.*);
`default_nettype wire

// File: test/tb.sv
// tb: self-checking bench for sprite_quad_batcher with random request and result stalls.
// A local batch/vertex predictor fills the expected-result queue; the monitor compares.
// Depends on sqb_pkg and design/sprite_quad_batcher.sv.
`timescale 1ns / 1ps
module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sqb_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sqb_pkg::out_item_t m_data;

    sprite_quad_batcher dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sqb_pkg::in_item_t request_q[$];
    int unsigned gap_q[$];
    sqb_pkg::out_item_t quad_q[$];

    // predictor state
    logic frame_on;
    int unsigned batch_count;
    logic [15:0] bound_tex;
    int unsigned draw_count;

    int errors = 0;
    logic stim_done = 1'b0;
    int unsigned hold_off = 0;
    logic sync_pause = 1'b0;
    int unsigned idle_cycles = 0;

    function automatic longint fshift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint rshift(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint qsine(int unsigned r);
        longint x, x2, p, s;
        x = longint'(r) << 16;
        x2 = fshift(x * x, 30);
        p = 172273;
        p = 5026995 - fshift(x2 * p, 30);
        p = 85569306 - fshift(x2 * p, 30);
        p = 693598668 - fshift(x2 * p, 30);
        p = 1686629713 - fshift(x2 * p, 30);
        s = rshift(fshift(x * p, 30), 16);
        if (s > 16384) s = 16384;
        if (s < 0) s = 0;
        return s;
    endfunction

    function automatic longint bsine(logic [15:0] a);
        longint v;
        v = a[14] ? qsine(16384 - a[13:0]) : qsine(a[13:0]);
        return a[15] ? -v : v;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic void close_batch();
        sqb_pkg::out_item_t o;
        if (batch_count == 0) return;
        o = '0;
        o.kind = sqb_pkg::KIND_DRAW;
        o.batch_texture = bound_tex;
        o.batch_sprites = batch_count[10:0];
        o.draw_number = draw_count[15:0];
        quad_q.insert(quad_q.size(), o);
        if (draw_count < 65535) draw_count++;
        batch_count = 0;
    endfunction

    function automatic void predict_request(sqb_pkg::in_item_t it);
        sqb_pkg::out_item_t o;
        longint px, py, w, h, gx, gy, ox, oy, ex, ey, c, s, rx, ry;
        longint cx[4], cy[4];
        int unsigned u0, v0, u1, v1;
        int unsigned cu[4], cv[4];
        int n0;
        n0 = quad_q.size();
        if (it.op == sqb_pkg::OP_BEGIN) begin
            frame_on = 1'b1;
            batch_count = 0;
            draw_count = 0;
            bound_tex = '0;
            return;
        end
        if (!frame_on) return;
        if (it.op == sqb_pkg::OP_SPRITE) begin
            if (bound_tex != 0 && bound_tex != it.texture_id) close_batch();
            if (batch_count >= sqb_pkg::BATCH_SPRITES_DEF) close_batch();
            bound_tex = it.texture_id;
            px = longint'($signed(it.position[63:32]));
            py = longint'($signed(it.position[31:0]));
            w = longint'($signed(it.extent[63:32]));
            h = longint'($signed(it.extent[31:0]));
            gx = longint'($signed(it.pivot[31:16]));
            gy = longint'($signed(it.pivot[15:0]));
            u0 = it.source_rect[63:48];
            v0 = it.source_rect[47:32];
            u1 = u0 + it.source_rect[31:16];
            v1 = v0 + it.source_rect[15:0];
            if (u1 > 65535) u1 = 65535;
            if (v1 > 65535) v1 = 65535;
            ox = rshift(-(gx * w), 12);
            oy = rshift(-(gy * h), 12);
            ex = ox + w;
            ey = oy + h;
            cx = '{ox, ex, ex, ox};
            cy = '{oy, oy, ey, ey};
            cu = '{u0, u1, u1, u0};
            cv = '{v0, v0, v1, v1};
            c = bsine(it.angle + 16'd16384);
            s = bsine(it.angle);
            for (int i = 0; i < 4; i++) begin
                rx = cx[i];
                ry = cy[i];
                if (it.angle != 0) begin
                    rx = rshift(cx[i] * c - cy[i] * s, 14);
                    ry = rshift(cx[i] * s + cy[i] * c, 14);
                end
                o = '0;
                o.kind = sqb_pkg::KIND_VERTEX;
                o.vertex_x = sat32(px + rx);
                o.vertex_y = sat32(py + ry);
                o.tex_u = cu[i][15:0];
                o.tex_v = cv[i][15:0];
                o.vertex_rgba = it.rgba;
                o.batch_texture = it.texture_id;
                quad_q.insert(quad_q.size(), o);
            end
            batch_count++;
        end else begin
            close_batch();
            if (it.op == sqb_pkg::OP_END) frame_on = 1'b0;
            o = '0;
            o.kind = sqb_pkg::KIND_BLEND;
            o.blend_mode = (it.op == sqb_pkg::OP_BLEND) ? it.blend_select : 1'b0;
            quad_q.insert(quad_q.size(), o);
        end
        if (quad_q.size() > n0) quad_q[$].last = 1'b1;
    endfunction

    function automatic sqb_pkg::in_item_t random_request(sqb_pkg::op_t op);
        sqb_pkg::in_item_t it;
        it.op = op;
        it.texture_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        it.position = {$urandom, $urandom};
        it.extent = {$urandom, $urandom};
        it.pivot = $urandom;
        it.angle = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
        it.source_rect = {$urandom, $urandom};
        it.rgba = $urandom;
        it.blend_select = 1'($urandom);
        if ($urandom_range(0, 1)) begin
            // moderate magnitudes keep most corners out of saturation
            it.position = {32'($signed(16'($urandom))) <<< 8, 32'($signed(16'($urandom))) <<< 8};
            it.extent = {32'($urandom_range(0, 1 << 22)), 32'($urandom_range(0, 1 << 22))};
        end
        return it;
    endfunction

    task automatic queue_request(sqb_pkg::in_item_t it);
        request_q.insert(request_q.size(), it);
        gap_q.insert(gap_q.size(), $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
    endtask

    // driver
    int unsigned send_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_request(s_data);
                void'(request_q.pop_front());
                void'(gap_q.pop_front());
                s_valid <= 1'b0;
                send_wait <= 0;
            end else if (!s_valid && request_q.size() > 0 && !sync_pause) begin
                if (send_wait >= gap_q[0]) begin
                    s_valid <= 1'b1;
                    s_data <= request_q[0];
                end else begin
                    send_wait <= send_wait + 1;
                end
            end
        end
    end

    // monitor
    int unsigned recv_wait = 0;
    int unsigned recv_gap = 0;
    always @(posedge aclk) begin
        sqb_pkg::out_item_t exp_item;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (quad_q.size() == 0) begin
                    $error("unexpected result kind=%0d", m_data.kind);
                    errors++;
                end else begin
                    exp_item = quad_q.pop_front();
                    if (m_data.kind !== exp_item.kind) begin
                        $error("kind exp %0d got %0d", exp_item.kind, m_data.kind); errors++;
                    end
                    if (m_data.vertex_x !== exp_item.vertex_x) begin
                        $error("vertex_x exp %h got %h", exp_item.vertex_x, m_data.vertex_x);
                        errors++;
                    end
                    if (m_data.vertex_y !== exp_item.vertex_y) begin
                        $error("vertex_y exp %h got %h", exp_item.vertex_y, m_data.vertex_y);
                        errors++;
                    end
                    if (m_data.tex_u !== exp_item.tex_u) begin
                        $error("tex_u exp %h got %h", exp_item.tex_u, m_data.tex_u); errors++;
                    end
                    if (m_data.tex_v !== exp_item.tex_v) begin
                        $error("tex_v exp %h got %h", exp_item.tex_v, m_data.tex_v); errors++;
                    end
                    if (m_data.vertex_rgba !== exp_item.vertex_rgba) begin
                        $error("vertex_rgba exp %h got %h", exp_item.vertex_rgba,
                            m_data.vertex_rgba);
                        errors++;
                    end
                    if (m_data.batch_texture !== exp_item.batch_texture) begin
                        $error("batch_texture exp %h got %h", exp_item.batch_texture,
                            m_data.batch_texture);
                        errors++;
                    end
                    if (m_data.batch_sprites !== exp_item.batch_sprites) begin
                        $error("batch_sprites exp %0d got %0d", exp_item.batch_sprites,
                            m_data.batch_sprites);
                        errors++;
                    end
                    if (m_data.draw_number !== exp_item.draw_number) begin
                        $error("draw_number exp %0d got %0d", exp_item.draw_number,
                            m_data.draw_number);
                        errors++;
                    end
                    if (m_data.blend_mode !== exp_item.blend_mode) begin
                        $error("blend_mode exp %0d got %0d", exp_item.blend_mode,
                            m_data.blend_mode);
                        errors++;
                    end
                    if (m_data.last !== exp_item.last) begin
                        $error("last exp %0d got %0d", exp_item.last, m_data.last); errors++;
                    end
                end
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                recv_wait <= 0;
                m_ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (recv_wait >= recv_gap) begin
                m_ready <= 1'b1;
            end else begin
                recv_wait <= recv_wait + 1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn && !stim_done) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (request_q.size() > 0 || s_valid || quad_q.size() > 0) @(posedge aclk);
    endtask

    initial begin
        sqb_pkg::in_item_t it;
        frame_on = 1'b0;
        batch_count = 0;
        bound_tex = '0;
        draw_count = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle-frame requests, extremes, texture zero, begin inside a frame
        queue_request(random_request(sqb_pkg::OP_SPRITE));
        queue_request(random_request(sqb_pkg::OP_BLEND));
        queue_request(random_request(sqb_pkg::OP_END));
        queue_request(random_request(sqb_pkg::OP_BEGIN));
        it = random_request(sqb_pkg::OP_SPRITE);
        it.texture_id = 16'd0; it.angle = 16'd0;
        it.position = {32'h7fffffff, 32'h80000000};
        it.extent = {32'h7fffffff, 32'h80000000};
        it.pivot = {16'h8000, 16'h7fff};
        it.source_rect = '1; it.rgba = '1;
        queue_request(it);
        it.texture_id = 16'hffff; it.angle = 16'hffff;
        it.position = '0; it.extent = '0; it.pivot = '0; it.source_rect = '0; it.rgba = '0;
        queue_request(it);
        for (int b = 0; b < 16; b++) begin
            it = random_request(sqb_pkg::OP_SPRITE);
            it.texture_id = 16'hffff;
            it.angle = 16'd1 << b;
            queue_request(it);
        end
        it = random_request(sqb_pkg::OP_SPRITE); it.angle = 16'h4000; queue_request(it);
        it = random_request(sqb_pkg::OP_BLEND); it.blend_select = 1'b1; queue_request(it);
        it = random_request(sqb_pkg::OP_BLEND); it.blend_select = 1'b0; queue_request(it);
        queue_request(random_request(sqb_pkg::OP_SPRITE));
        queue_request(random_request(sqb_pkg::OP_BEGIN));
        queue_request(random_request(sqb_pkg::OP_END));
        queue_request(random_request(sqb_pkg::OP_END));

        // long receiver stall while sprites keep coming
        wait_drained();
        queue_request(random_request(sqb_pkg::OP_BEGIN));
        for (int i = 0; i < 6; i++) queue_request(random_request(sqb_pkg::OP_SPRITE));
        hold_off = 400;
        wait_drained();

        // random frames, mostly well-formed
        for (int n = 0; n < 284; ) begin
            sqb_pkg::op_t op;
            int r;
            r = $urandom_range(0, 99);
            op = (r < 6) ? sqb_pkg::OP_BEGIN : (r < 80) ? sqb_pkg::OP_SPRITE :
                 (r < 92) ? sqb_pkg::OP_BLEND : sqb_pkg::OP_END;
            queue_request(random_request(op));
            n++;
            if (n == 142) begin
                wait_drained();
                sync_pause = 1'b1;
                repeat (20) @(posedge aclk);
                sync_pause = 1'b0;
            end
        end
        wait_drained();

        stim_done = 1'b1;
        repeat (200) @(posedge aclk);
        if (errors == 0 && quad_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
